@@ hdl/edrd_pkg.sv @@
// Shared types and constants for the dual encoder speed and distance block.
// Holds the beat structs, the controller command and status groups and the register map.
// Depends on nothing; every other file in hdl imports it.
package edrd_pkg;

    // Defaults for the top-level parameters.
    localparam int COUNT_BITS_DEF    = 32;
    localparam int RPM_FRAC_BITS_DEF = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_CIRC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ORIGIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ORIGN = 3'd6;

    localparam logic [15:0] INTERVAL_RST   = 16'd50;
    localparam logic [15:0] PULSES_REV_RST = 16'd12;
    localparam logic [15:0] GEAR_RATIO_RST = 16'd12800;
    localparam logic [31:0] WHEEL_CIRC_RST = 32'd491520;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int RPM_W   = 24;
    localparam int DIST_W  = 32;
    localparam int DEN_W   = 64;
    localparam int QCNT_W  = 6;

    // Arithmetic constants: ms per minute, Q8 gear fraction, and the distance
    // scale (Q16 circumference times 128 = 256 / 2 for the two-wheel average).
    localparam int unsigned MS_PER_MIN = 60000;
    localparam int          GEAR_FRAC  = 8;
    localparam int          DIST_SHIFT = 7;

    // Digit width of the shared multiplier.
    localparam int MUL_DIG_W = 16;

    typedef struct packed {
        logic        [TIME_W-1:0] time_ms;
        logic signed [CNT_W-1:0]  left_cnt;
        logic signed [CNT_W-1:0]  right_cnt;
    } t_in_item;

    typedef struct packed {
        logic signed [RPM_W-1:0]  left_rpm;
        logic signed [RPM_W-1:0]  right_rpm;
        logic signed [DIST_W-1:0] distance;
        logic signed [CNT_W-1:0]  left_raw;
        logic signed [CNT_W-1:0]  right_raw;
        logic        [TIME_W-1:0] stamp_ms;
        logic                     rpm_fresh;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_DIST
    } t_op;

    typedef struct packed {
        logic load;
        logic prep;
        logic den;
        logic mul_start;
        logic div_start;
        logic store;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic enable;
        logic due;
        logic mul_done;
        logic div_done;
        logic out_full;
    } t_sts;

endpackage

@@ hdl/dual_encoder_rpm_distance_top.sv @@
// Top level of the dual encoder speed and distance block.
// Joins edrd_ctrl and edrd_dp; types and constants come from edrd_pkg.

// Each input beat is one poll: a millisecond time and both wheel counts. With
// enable set, every poll yields one output beat carrying the held wheel RPMs
// (signed Q16.8), the averaged distance (signed Q16.16 inches), the raw counts,
// the poll time and a flag that is set when the speeds were recomputed; with
// enable clear a poll is taken and dropped. Speeds are recomputed once
// interval_ms has elapsed since the last recompute. The block works on one poll
// at a time and takes no new poll until the last one is through: a poll passes
// preparation, then the shared multiplier (one 16-bit digit per cycle) and the
// shared divider (one quotient bit per cycle, 24 bits per speed and 32 for
// distance) for each speed when recomputed and for the distance. The output
// register lets a new poll be taken while the last result still waits.
module dual_encoder_rpm_distance_top #(
    parameter int COUNT_BITS    = edrd_pkg::COUNT_BITS_DEF,
    parameter int RPM_FRAC_BITS = edrd_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edrd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [edrd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  edrd_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output edrd_pkg::t_out_item               o_out_data
);
    import edrd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    edrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    edrd_dp #(
        .COUNT_BITS    (COUNT_BITS),
        .RPM_FRAC_BITS (RPM_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hdl/edrd_mul.sv @@
// Sequential multiplier: one 16-bit digit of the first operand per cycle, MSB first.
// Used for both speed numerators and the distance numerator; depends on edrd_pkg.
module edrd_mul #(
    parameter int A_W = 34,
    parameter int B_W = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);
    import edrd_pkg::*;

    localparam int NDIG  = (A_W + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int AP_W  = NDIG * MUL_DIG_W;
    localparam int ACC_W = AP_W + B_W;
    localparam int CW    = $clog2(NDIG + 1);

    logic [AP_W-1:0]          r_a;
    logic [B_W-1:0]           r_b;
    logic [ACC_W-1:0]         r_acc;
    logic [CW-1:0]            r_cnt;
    logic                     r_done;
    logic [MUL_DIG_W+B_W-1:0] pp;

    assign pp = r_a[AP_W-1 -: MUL_DIG_W] * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= AP_W'(i_a);
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= CW'(NDIG);
            end else if (r_cnt != '0) begin
                r_acc <= (r_acc << MUL_DIG_W) + ACC_W'(pp);
                r_a   <= r_a << MUL_DIG_W;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[A_W+B_W-1:0];

endmodule

@@ hdl/edrd_div.sv @@
// Restoring divider, one quotient bit per cycle, with signed saturation.
// Produces 24 quotient bits for speeds or 32 for distance; depends on edrd_pkg.
module edrd_div #(
    parameter int NUM_W = 81
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_dist,
    input  logic                              i_neg,
    input  logic [NUM_W-1:0]                  i_num,
    input  logic [edrd_pkg::DEN_W-1:0]        i_den,
    output logic                              o_done,
    output logic [edrd_pkg::DIST_W-1:0]       o_q
);
    import edrd_pkg::*;

    localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [NUM_W-1:0]  hi;
    logic              over;
    logic [DEN_W:0]    r_rem;
    logic [DIST_W-1:0] r_bits;
    logic [DIST_W-1:0] r_q;
    logic [DEN_W-1:0]  r_den;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_sat;
    logic              r_neg;
    logic              r_dist;
    logic              r_done;
    logic [DEN_W:0]    sh;
    logic              ge;
    logic [DIST_W-1:0] lim_base;
    logic [DIST_W-1:0] lim;
    logic [DIST_W-1:0] qmag;

    // The quotient fits in the selected width exactly when the bits above it
    // are below the divisor; otherwise the result saturates.
    assign hi   = i_dist ? (i_num >> DIST_W) : (i_num >> RPM_W);
    assign over = CW'(hi) >= CW'(i_den);

    assign sh = {r_rem[DEN_W-1:0], r_bits[DIST_W-1]};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= (DEN_W + 1)'(hi);
                r_bits <= i_dist ? i_num[DIST_W-1:0]
                                 : {i_num[RPM_W-1:0], (DIST_W - RPM_W)'(0)};
                r_q    <= '0;
                r_den  <= i_den;
                r_sat  <= over;
                r_neg  <= i_neg;
                r_dist <= i_dist;
                r_cnt  <= i_dist ? QCNT_W'(DIST_W) : QCNT_W'(RPM_W);
            end else if (r_cnt != '0) begin
                r_rem  <= ge ? (sh - {1'b0, r_den}) : sh;
                r_q    <= {r_q[DIST_W-2:0], ge};
                r_bits <= r_bits << 1;
                r_cnt  <= r_cnt - QCNT_W'(1);
                if (r_cnt == QCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A negative result may reach one step further than a positive one.
    assign lim_base = r_dist ? (DIST_W'(1) << (DIST_W - 1)) : (DIST_W'(1) << (RPM_W - 1));
    assign lim      = r_neg ? lim_base : (lim_base - DIST_W'(1));
    assign qmag     = (r_sat || (r_q > lim)) ? lim : r_q;

    assign o_done = r_done;
    assign o_q    = r_neg ? (~qmag + DIST_W'(1)) : qmag;

endmodule

@@ hdl/edrd_dp.sv @@
// Datapath: configuration registers, wheel state, operand preparation, the shared
// multiplier and divider, and the output register. Depends on edrd_pkg, edrd_mul, edrd_div.
module edrd_dp #(
    parameter int COUNT_BITS    = edrd_pkg::COUNT_BITS_DEF,
    parameter int RPM_FRAC_BITS = edrd_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edrd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [edrd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  edrd_pkg::t_in_item                i_in_data,
    input  edrd_pkg::t_cmd                    i_cmd,
    output edrd_pkg::t_sts                    o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output edrd_pkg::t_out_item               o_out_data
);
    import edrd_pkg::*;

    // Count deltas of two 32-bit counts fit in 33 bits, so wrapping only
    // matters below that.
    localparam int DW   = (COUNT_BITS < CNT_W + 1) ? COUNT_BITS : CNT_W + 1;
    localparam int SW   = DW + 1;
    localparam int K_W  = 16 + GEAR_FRAC + RPM_FRAC_BITS;
    localparam int MA_W = (SW > 32) ? SW : 32;
    localparam int MB_W = (K_W > 32) ? K_W : 32;
    localparam int P_W  = MA_W + MB_W;
    localparam int N_W  = P_W + DIST_SHIFT;
    localparam logic [MB_W-1:0] RPM_K = MB_W'(MS_PER_MIN) << (GEAR_FRAC + RPM_FRAC_BITS);

    // Configuration.
    logic              r_enable;
    logic [15:0]       r_interval;
    logic [15:0]       r_ppr;
    logic [15:0]       r_gear;
    logic [31:0]       r_circ;
    logic [CNT_W-1:0]  r_lorg;
    logic [CNT_W-1:0]  r_rorg;

    // Wheel state.
    logic [TIME_W-1:0] r_last;
    logic [CNT_W-1:0]  r_lprev;
    logic [CNT_W-1:0]  r_rprev;
    logic [RPM_W-1:0]  r_lspeed;
    logic [RPM_W-1:0]  r_rspeed;

    // Per-poll working registers.
    t_in_item          r_in;
    logic [TIME_W-1:0] r_elapsed;
    logic              r_due;
    logic [31:0]       r_pg;
    logic [DEN_W-1:0]  r_den;
    logic [DW-1:0]     r_lmag;
    logic              r_lneg;
    logic [DW-1:0]     r_rmag;
    logic              r_rneg;
    logic [SW-1:0]     r_smag;
    logic              r_sneg;
    logic [DIST_W-1:0] r_dist;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [TIME_W-1:0] elapsed;
    logic [CNT_W:0]    ldiff, rdiff, lodiff, rodiff;
    logic [DW-1:0]     ldel, rdel, dl, dr;
    logic [SW-1:0]     dsum;
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic              mul_done;
    logic [P_W-1:0]    mul_prod;
    logic [N_W-1:0]    div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_neg;
    logic              div_done;
    logic [DIST_W-1:0] div_q;
    logic              div_dist;

    assign elapsed = r_in.time_ms - r_last;

    always_comb begin
        ldiff  = {r_in.left_cnt[CNT_W-1], r_in.left_cnt} - {r_lprev[CNT_W-1], r_lprev};
        rdiff  = {r_in.right_cnt[CNT_W-1], r_in.right_cnt} - {r_rprev[CNT_W-1], r_rprev};
        lodiff = {r_in.left_cnt[CNT_W-1], r_in.left_cnt} - {r_lorg[CNT_W-1], r_lorg};
        rodiff = {r_in.right_cnt[CNT_W-1], r_in.right_cnt} - {r_rorg[CNT_W-1], r_rorg};
        ldel   = ldiff[DW-1:0];
        rdel   = rdiff[DW-1:0];
        dl     = lodiff[DW-1:0];
        dr     = rodiff[DW-1:0];
        dsum   = {dl[DW-1], dl} + {dr[DW-1], dr};
    end

    // Configuration writes and wheel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_interval  <= INTERVAL_RST;
            r_ppr       <= PULSES_REV_RST;
            r_gear      <= GEAR_RATIO_RST;
            r_circ      <= WHEEL_CIRC_RST;
            r_lorg      <= '0;
            r_rorg      <= '0;
            r_last      <= '0;
            r_lprev     <= '0;
            r_rprev     <= '0;
            r_lspeed    <= '0;
            r_rspeed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE:      r_enable   <= i_cfg_data[0];
                    REG_INTERVAL_MS: r_interval <= i_cfg_data[15:0];
                    REG_PULSES_REV:  r_ppr      <= i_cfg_data[15:0];
                    REG_GEAR_RATIO:  r_gear     <= i_cfg_data[15:0];
                    REG_WHEEL_CIRC:  r_circ     <= i_cfg_data;
                    REG_LEFT_ORIGIN: r_lorg     <= i_cfg_data;
                    REG_RIGHT_ORIGN: r_rorg     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.prep && (elapsed >= TIME_W'(r_interval))) begin
                r_last  <= r_in.time_ms;
                r_lprev <= r_in.left_cnt;
                r_rprev <= r_in.right_cnt;
            end
            // A zero speed divisor forces both speeds to zero.
            if (i_cmd.store) begin
                case (i_cmd.op)
                    OP_LEFT:  r_lspeed <= (r_den == '0) ? '0 : div_q[RPM_W-1:0];
                    OP_RIGHT: r_rspeed <= (r_den == '0) ? '0 : div_q[RPM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_elapsed <= elapsed;
            r_due     <= elapsed >= TIME_W'(r_interval);
            r_pg      <= r_ppr * r_gear;
            r_lneg    <= ldel[DW-1];
            r_lmag    <= ldel[DW-1] ? (~ldel + DW'(1)) : ldel;
            r_rneg    <= rdel[DW-1];
            r_rmag    <= rdel[DW-1] ? (~rdel + DW'(1)) : rdel;
            r_sneg    <= dsum[SW-1];
            r_smag    <= dsum[SW-1] ? (~dsum + SW'(1)) : dsum;
        end
        if (i_cmd.den) begin
            r_den <= r_pg * r_elapsed;
        end
        if (i_cmd.store && (i_cmd.op == OP_DIST)) begin
            r_dist <= (r_pg == '0) ? '0 : div_q;
        end
        if (i_cmd.out_load) begin
            r_out.left_rpm  <= r_lspeed;
            r_out.right_rpm <= r_rspeed;
            r_out.distance  <= r_dist;
            r_out.left_raw  <= r_in.left_cnt;
            r_out.right_raw <= r_in.right_cnt;
            r_out.stamp_ms  <= r_in.time_ms;
            r_out.rpm_fresh <= r_due;
        end
    end

    // Operand selection for the shared units.
    always_comb begin
        case (i_cmd.op)
            OP_LEFT: begin
                mul_a   = MA_W'(r_lmag);
                mul_b   = RPM_K;
                div_neg = r_lneg;
            end
            OP_RIGHT: begin
                mul_a   = MA_W'(r_rmag);
                mul_b   = RPM_K;
                div_neg = r_rneg;
            end
            OP_DIST: begin
                mul_a   = MA_W'(r_smag);
                mul_b   = MB_W'(r_circ);
                div_neg = r_sneg;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                div_neg = 1'b0;
            end
        endcase
        div_dist = (i_cmd.op == OP_DIST);
        div_num  = div_dist ? {mul_prod, DIST_SHIFT'(0)} : N_W'(mul_prod);
        div_den  = div_dist ? DEN_W'(r_pg) : r_den;
    end

    edrd_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    edrd_div #(
        .NUM_W (N_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dist  (div_dist),
        .i_neg   (div_neg),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_sts.enable   = r_enable;
    assign o_sts.due      = r_due;
    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done;
    assign o_sts.out_full = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/edrd_ctrl.sv @@
// Controller: sequences one poll through preparation, the multiplier and the divider.
// Talks to the datapath only through the command and status structs of edrd_pkg.
module edrd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  edrd_pkg::t_sts i_sts,
    output edrd_pkg::t_cmd o_cmd
);
    import edrd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DEN,
        S_MUL,
        S_MUL_WAIT,
        S_DIV,
        S_DIV_WAIT,
        S_STORE,
        S_OUT
    } t_state;

    t_state r_state;
    t_op    r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DIST;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // A beat taken while disabled is dropped without effect.
                    if (i_in_valid && i_sts.enable) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: r_state <= S_DEN;
                S_DEN: begin
                    r_op    <= i_sts.due ? OP_LEFT : OP_DIST;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (i_sts.mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    case (r_op)
                        OP_LEFT: begin
                            r_op    <= OP_RIGHT;
                            r_state <= S_MUL;
                        end
                        OP_RIGHT: begin
                            r_op    <= OP_DIST;
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_OUT: begin
                    if (!i_sts.out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prep      = (r_state == S_PREP);
        o_cmd.den       = (r_state == S_DEN);
        o_cmd.mul_start = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.store     = (r_state == S_STORE);
        o_cmd.out_load  = (r_state == S_OUT) && !i_sts.out_full;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
